FILE: sv/sdrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrs_pkg: shared types and constants of the stereo range smoother
// Field widths, register indexes, register reset values and sequencer states.
// ----------------------------------------------------------------------------
package sdrs_pkg;

   // Pixel coordinate width of the blob positions
   localparam int COORD_BITS = 10;

   // Configuration register widths
   localparam int SCALE_W  = 24;
   localparam int WEIGHT_W = 16;
   localparam int THRESH_W = 21;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;

   // Range in Q13.8
   localparam int RANGE_W = 21;
   localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};

   // Divider: one quotient bit per step
   localparam int DIV_STEPS = SCALE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Moving-average datapath
   localparam int DIFF_W = RANGE_W + 1;
   localparam int PROD_W = WEIGHT_W + 1 + DIFF_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int FRAC_W = WEIGHT_W;

   // Register reset values
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1728484);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(655);
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1280);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_SCALE       = 2'd0,
      CSR_SMOOTHING_WEIGHT  = 2'd1,
      CSR_OUTLIER_THRESHOLD = 2'd2,
      CSR_UNUSED            = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_MUL  = 2'd2,
      ST_FIN  = 2'd3
   } seq_state_type;

endpackage

FILE: sv/sdrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrs_if: handshake channels of the stereo range smoother
// Request channel carries a blob pair, response channel carries one result.
// ----------------------------------------------------------------------------
interface sdrs_req_if
   import sdrs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] left_x;
   logic [COORD_BITS-1:0] right_x;

   modport source (output valid, output left_x, output right_x, input ready);
   modport sink   (input valid, input left_x, input right_x, output ready);
endinterface

interface sdrs_rsp_if
   import sdrs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_estimate;
   logic               used_average;
   logic               sample_rejected;
   logic               range_saturated;

   modport source (output valid, output range_estimate, output used_average,
                   output sample_rejected, output range_saturated, input ready);
   modport sink   (input valid, input range_estimate, input used_average,
                   input sample_rejected, input range_saturated, output ready);
endinterface

FILE: sv/stereo_disparity_range_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_disparity_range_smoother: stereo range with moving-average smoothing
// Range = K / (right_x - left_x) in Q13.8, smoothed by an exponential average,
// with the average returned when the raw range deviates past a threshold.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_bus  in   valid/ready        left_x, right_x
//  rsp_bus  out  valid/ready        range_estimate, used_average,
//                                   sample_rejected, range_saturated
//  csr_*    in   csr_we             csr_index, csr_wdata (write only)
//
//  A word with positive disparity goes from accept to result through the
//  restoring divider (one quotient bit per cycle), then the weight
//  multiplier, then the average update and outlier test. Zero disparity
//  skips the divider, negative disparity goes straight to the result. The
//  first sample loads the average and skips the multiplier. One word is
//  in flight at a time.
//  Synchronous reset loads the register defaults and marks the average empty.
//  The result register frees the request side; a stalled response holds the
//  sequencer in its final step only when the result register is still full.
// ----------------------------------------------------------------------------
module stereo_disparity_range_smoother
   import sdrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   sdrs_req_if.sink             req_bus,
   sdrs_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [SCALE_W-1:0]  scale_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [THRESH_W-1:0] thresh_ff;

   // Control state
   seq_state_type state_ff, state_in;
   logic          first_ff, first_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SCALE_W-1:0]    quo_ff, quo_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] disp_ff, disp_in;
   logic                  neg_ff, neg_in;
   logic [RANGE_W-1:0]    raw_ff, raw_in;
   logic                  sat_ff, sat_in;
   logic [RANGE_W-1:0]    avg_ff, avg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [RANGE_W-1:0]    out_range_ff, out_range_in;
   logic                  out_used_ff, out_used_in;
   logic                  out_rej_ff, out_rej_in;
   logic                  out_sat_ff, out_sat_in;

   // Combinational helpers
   logic signed [COORD_BITS:0] disp_s;
   logic [COORD_BITS:0]        trial;
   logic                       trial_ge;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [ACC_W-1:0]    acc;
   logic [RANGE_W-1:0]         new_avg;
   logic signed [DIFF_W-1:0]   dev_s;
   logic [RANGE_W-1:0]         dev_abs;
   logic                       out_free;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         weight_ff <= WEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANGE_SCALE:       scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_SMOOTHING_WEIGHT:  weight_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_OUTLIER_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Shared arithmetic terms
   always_comb begin
      disp_s   = $signed({1'b0, req_bus.right_x}) - $signed({1'b0, req_bus.left_x});
      trial    = {rem_ff[COORD_BITS-1:0], quo_ff[SCALE_W-1]};
      trial_ge = trial >= {1'b0, disp_ff};
      diff     = $signed({1'b0, raw_ff}) - $signed({1'b0, avg_ff});
      acc      = $signed({{(ACC_W-RANGE_W-FRAC_W){1'b0}}, avg_ff, {FRAC_W{1'b0}}})
                 + ACC_W'(prod_ff)
                 + $signed(ACC_W'(1) <<< (FRAC_W-1));
      new_avg  = acc[RANGE_W+FRAC_W-1:FRAC_W];
      dev_s    = $signed({1'b0, new_avg}) - $signed({1'b0, raw_ff});
      dev_abs  = dev_s[DIFF_W-1] ? RANGE_W'(-dev_s) : dev_s[RANGE_W-1:0];
      out_free = !rsp_valid_ff || rsp_bus.ready;
   end

   // Sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      disp_in      = disp_ff;
      neg_in       = neg_ff;
      raw_in       = raw_ff;
      sat_in       = sat_ff;
      avg_in       = avg_ff;
      prod_in      = prod_ff;
      out_range_in = out_range_ff;
      out_used_in  = out_used_ff;
      out_rej_in   = out_rej_ff;
      out_sat_in   = out_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               disp_in = disp_s[COORD_BITS-1:0];
               neg_in  = disp_s[COORD_BITS];
               quo_in  = scale_ff;
               rem_in  = '0;
               cnt_in  = '0;
               raw_in  = RANGE_MAX;
               sat_in  = 1'b1;
               if (disp_s[COORD_BITS]) begin
                  state_in = ST_FIN;
               end else if (disp_s == '0) begin
                  state_in = first_ff ? ST_FIN : ST_MUL;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // Restoring divide step: shift in one dividend bit, subtract if it fits
            rem_in = trial_ge ? (trial - {1'b0, disp_ff}) : trial;
            quo_in = {quo_ff[SCALE_W-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS-1)) begin
               if (quo_in[SCALE_W-1:RANGE_W] != '0) begin
                  raw_in = RANGE_MAX;
                  sat_in = 1'b1;
               end else begin
                  raw_in = quo_in[RANGE_W-1:0];
                  sat_in = 1'b0;
               end
               state_in = first_ff ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, weight_ff}) * diff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (neg_ff) begin
                  out_range_in = avg_ff;
                  out_used_in  = 1'b1;
                  out_rej_in   = 1'b1;
                  out_sat_in   = 1'b0;
               end else if (first_ff) begin
                  first_in     = 1'b0;
                  avg_in       = raw_ff;
                  out_range_in = raw_ff;
                  out_used_in  = 1'b0;
                  out_rej_in   = 1'b0;
                  out_sat_in   = sat_ff;
               end else begin
                  avg_in       = new_avg;
                  out_used_in  = dev_abs > thresh_ff;
                  out_range_in = (dev_abs > thresh_ff) ? new_avg : raw_ff;
                  out_rej_in   = 1'b0;
                  out_sat_in   = sat_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         avg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         avg_ff       <= avg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      disp_ff      <= disp_in;
      neg_ff       <= neg_in;
      raw_ff       <= raw_in;
      sat_ff       <= sat_in;
      prod_ff      <= prod_in;
      out_range_ff <= out_range_in;
      out_used_ff  <= out_used_in;
      out_rej_ff   <= out_rej_in;
      out_sat_ff   <= out_sat_in;
   end

   // Drive channel ports
   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.range_estimate  = out_range_ff;
   assign rsp_bus.used_average    = out_used_ff;
   assign rsp_bus.sample_rejected = out_rej_ff;
   assign rsp_bus.range_saturated = out_sat_ff;

endmodule

FILE: test/stereo_disparity_range_smoother_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_disparity_range_smoother_test: self-checking bench of the range smoother
// Drives blob pairs through the request channel under random gaps and
// stalls, and reprograms the scale, weight and threshold registers between
// phases. A scoreboard predicts every result word and compares it field by
// field.
// ----------------------------------------------------------------------------
module stereo_disparity_range_smoother_test;
   import sdrs_pkg::*;

   localparam int TAIL_CYCLES  = 40;
   localparam int WATCHDOG_MAX = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_PAIRS  = 300;

   typedef struct packed {
      logic [RANGE_W-1:0] range_estimate;
      logic               used_average;
      logic               sample_rejected;
      logic               range_saturated;
   } range_word_type;

   // Predicts result words from blob pairs and checks the words that come out
   class range_scoreboard;
      logic [SCALE_W-1:0]  range_scale;
      logic [WEIGHT_W-1:0] smoothing_weight;
      logic [THRESH_W-1:0] outlier_threshold;
      bit                  first_pending;
      logic [RANGE_W-1:0]  average_range;
      range_word_type      expected_words[$];
      int errors;
      int pairs_noted;
      int words_checked;
      int averaged_count;
      int rejected_count;
      int saturated_count;

      function new();
         range_scale       = SCALE_RESET;
         smoothing_weight  = WEIGHT_RESET;
         outlier_threshold = THRESH_RESET;
         first_pending     = 1'b1;
         average_range     = '0;
         errors            = 0;
         pairs_noted       = 0;
         words_checked     = 0;
         averaged_count    = 0;
         rejected_count    = 0;
         saturated_count   = 0;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         $display("ERROR @%0t: %s", $time, msg);
      endtask

      function void set_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
         case (idx)
            CSR_RANGE_SCALE:       range_scale       = value[SCALE_W-1:0];
            CSR_SMOOTHING_WEIGHT:  smoothing_weight  = value[WEIGHT_W-1:0];
            CSR_OUTLIER_THRESHOLD: outlier_threshold = value[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      // Compute the result word of one pair and advance the average
      function range_word_type predict_range(input logic [COORD_BITS-1:0] lx,
                                             input logic [COORD_BITS-1:0] rx);
         range_word_type     word;
         int                 disparity;
         logic [31:0]        quotient;
         logic [RANGE_W-1:0] raw;
         logic               clipped;
         logic [63:0]        acc;
         logic [RANGE_W-1:0] deviation;
         word      = '0;
         disparity = int'(rx) - int'(lx);
         // negative disparity: hold the average and return it
         if (disparity < 0) begin
            word.range_estimate  = average_range;
            word.used_average    = 1'b1;
            word.sample_rejected = 1'b1;
            return word;
         end
         clipped = 1'b0;
         if (disparity == 0) begin
            raw     = RANGE_MAX;
            clipped = 1'b1;
         end else begin
            quotient = 32'(range_scale) / 32'(disparity);
            if (quotient > 32'(RANGE_MAX)) begin
               raw     = RANGE_MAX;
               clipped = 1'b1;
            end else begin
               raw = quotient[RANGE_W-1:0];
            end
         end
         word.range_saturated = clipped;
         // first accepted sample loads the average
         if (first_pending) begin
            first_pending       = 1'b0;
            average_range       = raw;
            word.range_estimate = raw;
            return word;
         end
         acc = (64'd65536 - 64'(smoothing_weight)) * 64'(average_range)
             + 64'(smoothing_weight) * 64'(raw) + 64'd32768;
         average_range = acc[16 +: RANGE_W];
         deviation = (average_range > raw) ? average_range - raw : raw - average_range;
         if (32'(deviation) > 32'(outlier_threshold)) begin
            word.range_estimate = average_range;
            word.used_average   = 1'b1;
         end else begin
            word.range_estimate = raw;
         end
         return word;
      endfunction

      function void note_pair(input logic [COORD_BITS-1:0] lx,
                              input logic [COORD_BITS-1:0] rx);
         expected_words.push_back(predict_range(lx, rx));
         pairs_noted++;
      endfunction

      task check_result(input range_word_type got);
         range_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending: range %0d",
                                      got.range_estimate));
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.used_average)    averaged_count++;
         if (got.sample_rejected) rejected_count++;
         if (got.range_saturated) saturated_count++;
         if (got.range_estimate !== want.range_estimate)
            report_mismatch($sformatf("word %0d range_estimate got %0d want %0d",
                                      words_checked, got.range_estimate,
                                      want.range_estimate));
         if (got.used_average !== want.used_average)
            report_mismatch($sformatf("word %0d used_average got %b want %b",
                                      words_checked, got.used_average, want.used_average));
         if (got.sample_rejected !== want.sample_rejected)
            report_mismatch($sformatf("word %0d sample_rejected got %b want %b",
                                      words_checked, got.sample_rejected,
                                      want.sample_rejected));
         if (got.range_saturated !== want.range_saturated)
            report_mismatch($sformatf("word %0d range_saturated got %b want %b",
                                      words_checked, got.range_saturated,
                                      want.range_saturated));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   sdrs_req_if req_bus ();
   sdrs_rsp_if rsp_bus ();

   range_scoreboard sb;
   int send_gap_max;
   int recv_gap_max;
   int settings_applied;
   int idle_cycles;

   stereo_disparity_range_smoother dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock
   always #5 clock = ~clock;

   // Count cycles without any handshake and give up at the limit
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("ERROR: no word moved for %0d cycles", WATCHDOG_MAX);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one pair; called and returning at a falling edge
   task automatic send_pair(input logic [COORD_BITS-1:0] lx,
                            input logic [COORD_BITS-1:0] rx);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.left_x  <= lx;
      req_bus.right_x <= rx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_pair(lx, rx);
      @(negedge clock);
   endtask

   // Drop valid and wait until every pending word has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Write all three registers back to back; optionally poke the spare index
   task automatic apply_settings(input logic [SCALE_W-1:0]  scale,
                                 input logic [WEIGHT_W-1:0] weight,
                                 input logic [THRESH_W-1:0] thresh,
                                 input bit                  poke_spare);
      if (poke_spare) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_UNUSED;
         csr_wdata <= CSR_W'($urandom);
         @(negedge clock);
      end
      csr_we    <= 1'b1;
      csr_index <= CSR_RANGE_SCALE;
      csr_wdata <= CSR_W'(scale);
      sb.set_register(CSR_RANGE_SCALE, CSR_W'(scale));
      @(negedge clock);
      csr_index <= CSR_SMOOTHING_WEIGHT;
      csr_wdata <= CSR_W'(weight);
      sb.set_register(CSR_SMOOTHING_WEIGHT, CSR_W'(weight));
      @(negedge clock);
      csr_index <= CSR_OUTLIER_THRESHOLD;
      csr_wdata <= CSR_W'(thresh);
      sb.set_register(CSR_OUTLIER_THRESHOLD, CSR_W'(thresh));
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_applied++;
   endtask

   // Random pairs: mostly a drifting target disparity so the average settles,
   // mixed with wide jumps, tiny and zero disparity and rejected samples
   task automatic run_random_pairs(input int count);
      int target;
      int disparity;
      int pick;
      int lx;
      int rx;
      target = $urandom_range(1, 300);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            target = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023)
                                                 : $urandom_range(1, 200);
         if (n % 64 == 0)
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         pick = $urandom_range(0, 99);
         if (pick < 90) begin
            if (pick < 60)
               disparity = target + $urandom_range(0, 6) - 3;
            else if (pick < 75)
               disparity = $urandom_range(1, 1023);
            else if (pick < 83)
               disparity = $urandom_range(1, 8);
            else
               disparity = 0;
            if (disparity < 0)    disparity = 0;
            if (disparity > 1023) disparity = 1023;
            lx = $urandom_range(0, 1023 - disparity);
            rx = lx + disparity;
         end else begin
            rx = $urandom_range(0, 1022);
            lx = $urandom_range(rx + 1, 1023);
         end
         send_pair(COORD_BITS'(lx), COORD_BITS'(rx));
      end
   endtask

   // Result side: random stalls, one long hold-off to back up the block
   initial begin : response_side
      int             gap;
      bit             held_off;
      range_word_type got;
      held_off      = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && sb.words_checked >= 300) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.range_estimate  = rsp_bus.range_estimate;
         got.used_average    = rsp_bus.used_average;
         got.sample_rejected = rsp_bus.sample_rejected;
         got.range_saturated = rsp_bus.range_saturated;
         sb.check_result(got);
         if (sb.words_checked % 64 == 0)
            recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin : stimulus
      logic [SCALE_W-1:0]  scale;
      logic [WEIGHT_W-1:0] weight;
      logic [THRESH_W-1:0] thresh;
      sb               = new();
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_RANGE_SCALE;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.left_x   = '0;
      req_bus.right_x  = '0;
      send_gap_max     = 16;
      recv_gap_max     = 16;
      settings_applied = 0;
      idle_cycles      = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: rejected pair before any sample, zero disparity as
      // first sample, widest and narrowest disparity, rejected after samples
      send_pair(10'd1023, 10'd0);
      send_pair(10'd5, 10'd5);
      send_pair(10'd0, 10'd1);
      send_pair(10'd0, 10'd1023);
      send_pair(10'd1023, 10'd1023);
      send_pair(10'd512, 10'd511);
      send_pair(10'd0, 10'd0);
      send_pair(10'd100, 10'd101);
      drain();

      // Largest scale: quotient clipping and the exact top of the range
      apply_settings(SCALE_W'(24'hFFFFFF), WEIGHT_W'(16'hFFFF), '0, 1'b1);
      send_pair(10'd0, 10'd1);
      send_pair(10'd0, 10'd8);
      send_pair(10'd0, 10'd7);
      send_pair(10'd0, 10'd1023);
      send_pair(10'd700, 10'd300);
      drain();

      // Zero scale, frozen average, threshold never exceeded
      apply_settings('0, '0, THRESH_W'(21'h1FFFFF), 1'b0);
      send_pair(10'd0, 10'd1);
      send_pair(10'd3, 10'd900);
      send_pair(10'd0, 10'd0);
      drain();

      // Smallest scale, half weight, tight threshold
      apply_settings(SCALE_W'(1), WEIGHT_W'(32768), THRESH_W'(1), 1'b0);
      send_pair(10'd0, 10'd1);
      send_pair(10'd0, 10'd2);
      send_pair(10'd1022, 10'd1023);
      drain();

      // Random phases over default, extreme and random settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               scale = SCALE_RESET; weight = WEIGHT_RESET; thresh = THRESH_RESET;
            end
            2: begin
               scale = SCALE_W'(24'hFFFFFF); weight = WEIGHT_W'(16'hFFFF); thresh = '0;
            end
            3: begin
               scale = SCALE_W'(1); weight = '0; thresh = THRESH_W'(21'h1FFFFF);
            end
            default: begin
               scale  = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(0, 24'hFFFFFF))
                                                    : SCALE_W'($urandom_range(20000, 4000000));
               weight = WEIGHT_W'($urandom_range(0, 65535));
               thresh = ($urandom_range(0, 1) == 0) ? THRESH_W'($urandom_range(0, 21'h1FFFFF))
                                                    : THRESH_W'($urandom_range(0, 20000));
            end
         endcase
         apply_settings(scale, weight, thresh, phase == 1);
         run_random_pairs(PHASE_PAIRS);
         drain();
      end

      if (sb.expected_words.size() != 0)
         sb.report_mismatch($sformatf("%0d result words never arrived",
                                      sb.expected_words.size()));
      $display("Checked %0d result words from %0d blob pairs under %0d register settings.",
               sb.words_checked, sb.pairs_noted, settings_applied);
      $display("Averaged returns %0d, rejected samples %0d, saturated ranges %0d.",
               sb.averaged_count, sb.rejected_count, sb.saturated_count);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
sv/sdrs_pkg.sv
sv/sdrs_if.sv
sv/stereo_disparity_range_smoother.sv
test/stereo_disparity_range_smoother_test.sv
